>>> hdl/kissdf_pkg.sv
// Package for the KISS deframer with CRC-16/X.25 frame check sequence.
// Holds the link codes, field widths, register indexes and reset values.
// Has no dependencies; every other file of the block imports it.
package kissdf_pkg;

   localparam int BYTE_W    = 8;
   localparam int MAX_LEN_W = 11;
   localparam int MIN_LEN_W = 10;
   localparam int COUNT_W   = 11;
   localparam int FCS_W     = 16;
   localparam int CSR_ADDR_W = 1;

   localparam logic [BYTE_W-1:0] FEND    = 8'hC0;
   localparam logic [BYTE_W-1:0] FESC    = 8'hDB;
   localparam logic [BYTE_W-1:0] TFEND   = 8'hDC;
   localparam logic [BYTE_W-1:0] TFESC   = 8'hDD;
   localparam logic [BYTE_W-1:0] CMD_DATA = 8'h00;

   localparam logic [FCS_W-1:0]  CRC_INIT = 16'hFFFF;
   localparam logic [FCS_W-1:0]  CRC_POLY = 16'h8408;

   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 11'd330;
   localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 10'd15;

   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_FRAME_LEN = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_FRAME_LEN = 1'b1;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_DISCARD = 2'd2,
      KIND_ABORT   = 2'd3
   } kind_type;

endpackage

>>> hdl/kissdf_ifs.sv
// Valid/ready channel interfaces of the KISS deframer: received bytes,
// results and register writes. Depends on kissdf_pkg.
interface kissdf_req_if;
   import kissdf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface kissdf_rsp_if;
   import kissdf_pkg::*;
   logic                 valid;
   logic                 ready;
   kind_type             kind;
   logic [BYTE_W-1:0]    data_byte;
   logic [FCS_W-1:0]     fcs;
   logic [COUNT_W-1:0]   frame_length;
   modport source (output valid, output kind, output data_byte, output fcs,
                   output frame_length, input ready);
   modport sink (input valid, input kind, input data_byte, input fcs,
                 input frame_length, output ready);
endinterface

interface kissdf_csr_if;
   import kissdf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [MAX_LEN_W-1:0]  data;
   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface

>>> hdl/kissdf_crc_byte.sv
// One-byte update of the reflected CRC-16/X.25 (polynomial 0x8408).
// Combinational; depends on kissdf_pkg.
module kissdf_crc_byte (
   input  logic [kissdf_pkg::FCS_W-1:0]  crc_cur,
   input  logic [kissdf_pkg::BYTE_W-1:0] data,
   output logic [kissdf_pkg::FCS_W-1:0]  crc_nxt
);
   import kissdf_pkg::*;

   always_comb begin
      logic [FCS_W-1:0] c;
      c = crc_cur ^ {{(FCS_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_nxt = c;
   end

endmodule

>>> hdl/kiss_deframer_with_fcs.sv
// KISS host-link deframer with CRC-16/X.25 frame check sequence.
// Top level; depends on kissdf_pkg, kissdf_ifs and kissdf_crc_byte.
//
// Usage: the req channel carries one serial byte per transfer. A 0x00
// command byte after FEND opens a data frame; in a frame, escapes are
// removed and each data byte leaves on the rsp channel as kind 0. FEND
// ends the frame with a frame-good result (FCS, length plus two), or
// gives a length discard and restarts it; a bad escape or an overlong
// frame gives an abort. Each byte causes at most one result transfer.
// The csr channel writes max_frame_len (index 0) and min_frame_len
// (index 1); it is always ready. The user must see that it is written
// only while idle; the block does not enforce this. A byte is decoded
// and its CRC updated in the cycle in which it is taken; its result
// is on the rsp channel in the next cycle. One byte is accepted per
// cycle; if the receiver stalls, the result register holds and req
// ready drops until taken. Reset returns to idle, registers at 330 and 15.
module kiss_deframer_with_fcs (
   input  logic        clock,
   input  logic        reset,
   kissdf_req_if.sink  req,
   kissdf_rsp_if.source rsp,
   kissdf_csr_if.sink  csr
);
   import kissdf_pkg::*;

   logic [MAX_LEN_W-1:0] max_len_ff;
   logic [MIN_LEN_W-1:0] min_len_ff;
   logic [BYTE_W-1:0]    prev_ff;
   logic                 receiving_ff, receiving_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [FCS_W-1:0]     crc_ff, crc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             kind_ff, kind_in;
   logic [BYTE_W-1:0]    data_ff, data_in;
   logic [FCS_W-1:0]     fcs_ff, fcs_in;
   logic [COUNT_W-1:0]   len_ff, len_in;

   logic                 accept;
   logic                 emit;
   logic [BYTE_W-1:0]    data_sel;
   logic [FCS_W-1:0]     crc_upd;
   logic [COUNT_W:0]     count_p1;
   logic [COUNT_W:0]     count_p2;
   logic                 overflow;
   logic                 len_good;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign count_p1 = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};
   assign count_p2 = {1'b0, count_ff} + (COUNT_W+1)'(2);
   assign overflow = count_p1 > {{(COUNT_W+1-MAX_LEN_W){1'b0}}, max_len_ff};
   assign len_good = (count_p2 < {{(COUNT_W+1-MAX_LEN_W){1'b0}}, max_len_ff})
                     && (count_ff >= {{(COUNT_W-MIN_LEN_W){1'b0}}, min_len_ff});

   always_comb begin
      if (prev_ff == FESC) begin
         data_sel = (req.rx_byte == TFESC) ? FESC : FEND;
      end else begin
         data_sel = req.rx_byte;
      end
   end

   kissdf_crc_byte u_crc (
      .crc_cur (crc_ff),
      .data    (data_sel),
      .crc_nxt (crc_upd)
   );

   always_comb begin
      logic take;
      take         = 1'b0;
      emit         = 1'b0;
      receiving_in = receiving_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      kind_in      = KIND_DATA;
      data_in      = '0;
      fcs_in       = '0;
      len_in       = '0;
      if (receiving_ff) begin
         priority if (prev_ff == FESC) begin
            if (req.rx_byte == TFESC || req.rx_byte == TFEND) begin
               take = 1'b1;
            end else begin
               emit         = 1'b1;
               kind_in      = KIND_ABORT;
               receiving_in = 1'b0;
               count_in     = '0;
               crc_in       = CRC_INIT;
            end
         end else if (req.rx_byte == FESC) begin
            emit = 1'b0;
         end else if (req.rx_byte == FEND) begin
            emit     = 1'b1;
            count_in = '0;
            crc_in   = CRC_INIT;
            if (len_good) begin
               kind_in      = KIND_GOOD;
               fcs_in       = ~crc_ff;
               len_in       = count_p2[COUNT_W-1:0];
               receiving_in = 1'b0;
            end else begin
               kind_in = KIND_DISCARD;
            end
         end else begin
            take = 1'b1;
         end
         if (take) begin
            emit = 1'b1;
            if (overflow) begin
               kind_in      = KIND_ABORT;
               receiving_in = 1'b0;
               count_in     = '0;
               crc_in       = CRC_INIT;
            end else begin
               kind_in  = KIND_DATA;
               data_in  = data_sel;
               crc_in   = crc_upd;
               count_in = count_p1[COUNT_W-1:0];
            end
         end
      end else if (prev_ff == FEND && req.rx_byte == CMD_DATA) begin
         receiving_in = 1'b1;
         count_in     = '0;
         crc_in       = CRC_INIT;
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         min_len_ff   <= MIN_LEN_RESET;
         prev_ff      <= '0;
         receiving_ff <= 1'b0;
         count_ff     <= '0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            unique case (csr.addr)
               CSR_MAX_FRAME_LEN: max_len_ff <= csr.data;
               CSR_MIN_FRAME_LEN: min_len_ff <= csr.data[MIN_LEN_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            prev_ff      <= req.rx_byte;
            receiving_ff <= receiving_in;
            count_ff     <= count_in;
            crc_ff       <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         fcs_ff  <= fcs_in;
         len_ff  <= len_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = kind_ff;
   assign rsp.data_byte    = data_ff;
   assign rsp.fcs          = fcs_ff;
   assign rsp.frame_length = len_ff;

endmodule
